// ----- rtl/strf_pkg.sv -----
// Shared definitions for the SumThreshold row flagger.
// Register map, field widths, defaults and the control bundle of the statistics unit.
// No dependencies.
package strf_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int WL_W   = 3;
  localparam int THR_W  = 23;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [WL_W-1:0]  WL_RESET  = '0;
  localparam logic [THR_W-1:0] THR_RESET = '1;

  // Register index, taken from paddr[2].
  localparam logic REG_WINDOW_LOG2 = 1'b0;
  localparam logic REG_THRESHOLD   = 1'b1;

  typedef struct packed {
    logic clear;
    logic add;
    logic sub;
  } stats_ctrl_t;

endpackage

// ----- rtl/strf_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the sample delay line. Depends on nothing.
module strf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/strf_stats.sv -----
// Running window statistics: signed sum and count of unflagged samples, and the trip test.
// Depends on strf_pkg for the control bundle and the threshold width.
module strf_stats import strf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int CW          = 7
) (
  input  logic                   clk,
  input  logic                   rst,
  input  stats_ctrl_t            ctrl,
  input  logic [SAMPLE_BITS-1:0] add_value,
  input  logic [SAMPLE_BITS-1:0] sub_value,
  input  logic [THR_W-1:0]       threshold,
  output logic                   trip
);

  localparam int SUM_W = SAMPLE_BITS + CW;
  localparam int CMP_W = SUM_W + THR_W;

  logic signed [SUM_W-1:0] sum, sum_next, sum_base;
  logic [CW-1:0]           count, count_next, count_base;
  logic [SUM_W-1:0]        mag;
  logic [THR_W+CW-1:0]     limit;

  always_comb begin
    sum_base   = ctrl.clear ? '0 : sum;
    count_base = ctrl.clear ? '0 : count;
    sum_next   = sum_base;
    count_next = count_base;
    priority if (ctrl.add) begin
      sum_next   = sum_base + {{CW{add_value[SAMPLE_BITS-1]}}, add_value};
      count_next = count_base + CW'(1);
    end else if (ctrl.sub) begin
      sum_next   = sum_base - {{CW{sub_value[SAMPLE_BITS-1]}}, sub_value};
      count_next = count_base - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
    end else begin
      sum   <= sum_next;
      count <= count_next;
    end
  end

  // |sum| > threshold * count is the exact integer form of |mean| > threshold.
  assign mag   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign limit = THR_W'(threshold) * (THR_W+CW)'(count);
  assign trip  = (count != '0) && (CMP_W'(mag) > CMP_W'(limit));

endmodule

// ----- rtl/sumthreshold_row_flagger_core.sv -----
// SumThreshold row flagger, top level: configuration registers, sequencer and output stage.
// Depends on strf_pkg, strf_ram and strf_stats.
//
// Usage. Samples enter on the sample channel (sample_valid/sample_ready) with their
// incoming mask bit and an end-of-row mark; flags leave on the result channel
// (result_valid/result_ready), one transfer per sample, in arrival order, each
// L-1 samples after the sample itself, where L = 2^window_log2 (at most MAX_WINDOW).
// The last result of a row carries row_done.
// Sequencing. A sample that causes no result passes the accept and check states
// (IDLE, CHECK); one that does also passes the pop state (POP), and its result is
// registered as it leaves POP. The buffered samples live in one RAM with a registered
// read, so the flush at a row end takes each buffered sample through FLUSH_WAIT and FLUSH_EMIT.
// A result waiting in the output register does not stop the next sample being
// taken; a stalled receiver only holds the sequencer when it has a further
// result to place. Reset clears the window, the output valid bit and the
// registers (window_log2 = 0, threshold = all ones); the delay RAM is not cleared.
// Writing window_log2 discards the samples buffered for the current row.
module sumthreshold_row_flagger_core import strf_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_ready,
  input  logic [SAMPLE_BITS-1:0] sample_value,
  input  logic                   already_flagged,
  input  logic                   row_end,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic                   flag_out,
  output logic                   row_done,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int MW = SAMPLE_BITS + 1;

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_CHECK      = 3'd1;
  localparam logic [2:0] S_POP        = 3'd2;
  localparam logic [2:0] S_FLUSH_WAIT = 3'd3;
  localparam logic [2:0] S_FLUSH_EMIT = 3'd4;

  logic [2:0]             state, state_next;
  logic [WL_W-1:0]        window_log2;
  logic [THR_W-1:0]       threshold;
  logic [AW-1:0]          head, head_inc, tail;
  logic [AW:0]            tail_sum;
  logic [CW-1:0]          fill, fill_eff, pending, len;
  logic [7:0]             len_pow;
  logic                   smp_flag, smp_last, was_empty;
  logic [SAMPLE_BITS-1:0] smp_value, oldest_value;
  logic                   oldest_flag;
  logic [MW-1:0]          rdata;
  logic                   accept, cfg_write, wl_write, slot_free, trip;
  logic                   emit, emit_flag, emit_done, row_clear;
  stats_ctrl_t            sctrl;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign wl_write  = cfg_write && (paddr[2] == REG_WINDOW_LOG2);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_log2 <= WL_RESET;
      threshold   <= THR_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_WINDOW_LOG2: window_log2 <= pwdata[WL_W-1:0];
        REG_THRESHOLD:   threshold   <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WINDOW_LOG2: prdata = DATA_W'(window_log2);
      REG_THRESHOLD:   prdata = DATA_W'(threshold);
      default:         prdata = '0;
    endcase
  end

  assign len_pow = 8'd1 << window_log2;
  assign len     = (len_pow > 8'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : len_pow[CW-1:0];

  assign sample_ready = (state == S_IDLE);
  assign accept       = sample_valid && sample_ready;
  assign fill_eff     = (fill >= len) ? '0 : fill;

  assign tail_sum = {1'b0, head} + (AW+1)'(fill_eff);
  assign tail     = (tail_sum >= (AW+1)'(MAX_WINDOW)) ?
                    AW'(tail_sum - (AW+1)'(MAX_WINDOW)) : tail_sum[AW-1:0];
  assign head_inc = (head == AW'(MAX_WINDOW - 1)) ? '0 : head + AW'(1);

  strf_ram #(.WIDTH(MW), .DEPTH(MAX_WINDOW), .AW(AW)) u_delay (
    .clk   (clk),
    .we    (accept),
    .waddr (tail),
    .wdata ({already_flagged, sample_value}),
    .raddr (head),
    .rdata (rdata)
  );

  assign slot_free = !result_valid || result_ready;

  always_comb begin
    emit       = 1'b0;
    emit_flag  = 1'b0;
    emit_done  = 1'b0;
    row_clear  = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (fill == len) begin
          state_next = S_POP;
        end else if (smp_last) begin
          state_next = S_FLUSH_WAIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_POP: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_flag = oldest_flag || (pending != '0);
          if (smp_last && fill == CW'(1)) begin
            emit_done  = 1'b1;
            row_clear  = 1'b1;
            state_next = S_IDLE;
          end else if (smp_last) begin
            state_next = S_FLUSH_WAIT;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_FLUSH_WAIT: begin
        state_next = S_FLUSH_EMIT;
      end
      S_FLUSH_EMIT: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_flag = rdata[MW-1] || (pending != '0);
          if (fill == CW'(1)) begin
            emit_done  = 1'b1;
            row_clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_FLUSH_WAIT;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    sctrl.clear = wl_write || row_clear || (accept && fill >= len);
    sctrl.add   = accept && !already_flagged;
    sctrl.sub   = emit && (state == S_POP) && !oldest_flag && !row_clear;
  end

  strf_stats #(.SAMPLE_BITS(SAMPLE_BITS), .CW(CW)) u_stats (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (sctrl),
    .add_value (sample_value),
    .sub_value (oldest_value),
    .threshold (threshold),
    .trip      (trip)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      fill    <= '0;
      pending <= '0;
      head    <= '0;
    end else begin
      state <= state_next;
      if (wl_write || row_clear) begin
        fill    <= '0;
        pending <= '0;
        if (row_clear) begin
          head <= head_inc;
        end
      end else if (accept) begin
        fill <= fill_eff + CW'(1);
        if (fill >= len) begin
          pending <= '0;
        end
      end else if (state == S_CHECK && fill == len && trip) begin
        pending <= len;
      end else if (emit) begin
        fill <= fill - CW'(1);
        head <= head_inc;
        if (pending != '0) begin
          pending <= pending - CW'(1);
        end
      end
    end
  end

  // The oldest entry is the new sample itself when the buffer was empty, since
  // the RAM read and the write of that entry fall on the same edge.
  always_ff @(posedge clk) begin
    if (accept) begin
      smp_value <= sample_value;
      smp_flag  <= already_flagged;
      smp_last  <= row_end;
      was_empty <= (fill_eff == '0);
    end
    if (state == S_CHECK) begin
      oldest_value <= was_empty ? smp_value : rdata[SAMPLE_BITS-1:0];
      oldest_flag  <= was_empty ? smp_flag  : rdata[MW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      flag_out <= emit_flag;
      row_done <= emit_done;
    end
  end

endmodule

// ----- rtl/strf_checker.sv -----
// Port-level checker for sumthreshold_row_flagger_core, attached by the bind below.
// Depends only on the top level's handshake, result and configuration ports.
module strf_checker (
  input logic clk,
  input logic rst,
  input logic sample_valid,
  input logic sample_ready,
  input logic result_valid,
  input logic result_ready,
  input logic flag_out,
  input logic row_done,
  input logic psel,
  input logic penable,
  input logic pready
);

  // A held result must not change while the receiver stalls.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(flag_out) && $stable(row_done))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid straight after reset");

  // Every sample needs at least a window check before the next transfer is taken.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("second sample taken on the next cycle");

  a_no_wait: assert property (@(posedge clk) disable iff (rst)
    psel && penable |-> pready)
    else $error("configuration access stalled");

endmodule

bind sumthreshold_row_flagger_core strf_checker u_strf_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_ready (sample_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .flag_out     (flag_out),
  .row_done     (row_done),
  .psel         (psel),
  .penable      (penable),
  .pready       (pready)
);
